// ===== design/q15a_pkg.sv =====
// Shared types, constants and the restoring-division step for the Q15 ALU.
`timescale 1ns / 1ps

package q15a_pkg;

    localparam int WordW         = 16;
    localparam int FracW         = 15;
    localparam int DivStages     = 8;
    localparam int StepsPerStage = WordW / DivStages;

    localparam logic signed [WordW-1:0] Q15Max = 16'sh7fff;
    localparam logic signed [WordW-1:0] Q15Min = 16'sh8000;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // One item in flight; divider fields are ignored for other commands.
    typedef struct packed {
        cmd_t                      cmd;
        logic signed [WordW:0]     sum;
        logic signed [2*WordW-1:0] prod;
        logic                      div_zero;
        logic                      a_zero;
        logic                      a_neg;
        logic                      q_neg;
        logic                      ovf;
        logic [WordW-1:0]          divisor;
        logic [WordW-1:0]          rem;
        logic [WordW-1:0]          lo;
        logic [WordW-1:0]          quo;
    } pipe_t;

    typedef struct packed {
        logic             qbit;
        logic [WordW-1:0] rem;
    } step_t;

    // One restoring step: shift in a dividend bit, subtract if it fits.
    function automatic step_t div_step(logic [WordW-1:0] rem, logic [WordW-1:0] divisor,
                                       logic bit_in);
        logic [WordW:0] trial;
        step_t          res;
        trial = {rem, bit_in};
        if (trial >= {1'b0, divisor})
        begin
            res.qbit = 1'b1;
            res.rem  = WordW'(trial - {1'b0, divisor});
        end
        else
        begin
            res.qbit = 1'b0;
            res.rem  = trial[WordW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/q15_saturating_alu_top.sv =====
// Top level of the pipelined Q15 saturating ALU (add, subtract, multiply, divide).
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// request   req_valid / req_ready  command[1:0], operand_a[15:0], operand_b[15:0]
// response  rsp_valid / rsp_ready  result[15:0]
//
// Every command flows through the same ten register stages: one input stage
// (operand magnitudes, add/subtract, 16x16 product), eight divider stages of two
// restoring steps each, and one output stage (rescale, saturate, select).
// One beat is accepted per cycle while the output register is empty or the response side takes.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the response side freezes the whole pipeline at once, so no beat
// is lost or repeated; req_ready follows rsp_ready when the output holds a beat.

module q15_saturating_alu_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [1:0]                        command,
    input  logic signed [q15a_pkg::WordW-1:0] operand_a,
    input  logic signed [q15a_pkg::WordW-1:0] operand_b,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic signed [q15a_pkg::WordW-1:0] result
);

    // Advance every stage when the output register is empty or being drained.
    logic advance;

    // Stage links: index 0 is the input stage, the last one feeds the output stage.
    logic            stage_valid [q15a_pkg::DivStages+1];
    q15a_pkg::pipe_t stage_pipe  [q15a_pkg::DivStages+1];

    assign advance   = !rsp_valid || rsp_ready;
    assign req_ready = advance;

    q15a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (req_valid),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (stage_valid[0]),
        .out_pipe  (stage_pipe[0])
    );

    // Divider chain: each stage retires two quotient bits.
    for (genvar s = 0; s < q15a_pkg::DivStages; s++)
    begin : g_div
        q15a_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (stage_valid[s]),
            .in_pipe   (stage_pipe[s]),
            .out_valid (stage_valid[s+1]),
            .out_pipe  (stage_pipe[s+1])
        );
    end

    q15a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (stage_valid[q15a_pkg::DivStages]),
        .in_pipe    (stage_pipe[q15a_pkg::DivStages]),
        .out_valid  (rsp_valid),
        .out_result (result)
    );

endmodule

// ===== design/q15a_front.sv =====
// Input stage: operand magnitudes, add/subtract, product and divider setup.
`timescale 1ns / 1ps

module q15a_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [1:0]                        command,
    input  logic signed [q15a_pkg::WordW-1:0] operand_a,
    input  logic signed [q15a_pkg::WordW-1:0] operand_b,
    output logic                              out_valid,
    output q15a_pkg::pipe_t                   out_pipe
);

    logic            valid_reg;
    q15a_pkg::pipe_t pipe_reg;
    q15a_pkg::pipe_t pipe_next;

    logic [q15a_pkg::WordW-1:0] a_mag;
    logic [q15a_pkg::WordW-1:0] b_mag;

    always_comb
    begin
        a_mag = operand_a[q15a_pkg::WordW-1] ? q15a_pkg::WordW'(~operand_a + 1'b1)
                                             : operand_a;
        b_mag = operand_b[q15a_pkg::WordW-1] ? q15a_pkg::WordW'(~operand_b + 1'b1)
                                             : operand_b;

        pipe_next.cmd = q15a_pkg::cmd_t'(command);
        if (q15a_pkg::cmd_t'(command) == q15a_pkg::CMD_SUB)
            pipe_next.sum = {operand_a[q15a_pkg::WordW-1], operand_a}
                          - {operand_b[q15a_pkg::WordW-1], operand_b};
        else
            pipe_next.sum = {operand_a[q15a_pkg::WordW-1], operand_a}
                          + {operand_b[q15a_pkg::WordW-1], operand_b};
        pipe_next.prod = (2*q15a_pkg::WordW)'(operand_a) * (2*q15a_pkg::WordW)'(operand_b);

        pipe_next.div_zero = (operand_b == '0);
        pipe_next.a_zero   = (operand_a == '0);
        pipe_next.a_neg    = operand_a[q15a_pkg::WordW-1];
        pipe_next.q_neg    = operand_a[q15a_pkg::WordW-1] ^ operand_b[q15a_pkg::WordW-1];
        // Quotient reaches 2^16 exactly when |a| >= 2|b|.
        pipe_next.ovf      = ({1'b0, a_mag} >= {b_mag, 1'b0});
        pipe_next.divisor  = b_mag;
        // Dividend |a| << 15: high part seeds the remainder, low bit leads the rest.
        pipe_next.rem      = a_mag >> 1;
        pipe_next.lo       = {a_mag[0], {(q15a_pkg::WordW-1){1'b0}}};
        pipe_next.quo      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

// ===== design/q15a_div_stage.sv =====
// Divider pipeline stage: a fixed number of restoring steps, other fields ride along.
`timescale 1ns / 1ps

module q15a_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  q15a_pkg::pipe_t in_pipe,
    output logic            out_valid,
    output q15a_pkg::pipe_t out_pipe
);

    logic            valid_reg;
    q15a_pkg::pipe_t pipe_reg;
    q15a_pkg::pipe_t pipe_next;

    always_comb
    begin
        q15a_pkg::step_t st;
        pipe_next = in_pipe;
        for (int i = 0; i < q15a_pkg::StepsPerStage; i++)
        begin
            st = q15a_pkg::div_step(pipe_next.rem, pipe_next.divisor,
                                    pipe_next.lo[q15a_pkg::WordW-1]);
            pipe_next.rem = st.rem;
            pipe_next.lo  = {pipe_next.lo[q15a_pkg::WordW-2:0], 1'b0};
            pipe_next.quo = {pipe_next.quo[q15a_pkg::WordW-2:0], st.qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pipe_reg <= pipe_next;
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

// ===== design/q15a_back.sv =====
// Output stage: rescale the product, saturate and pick the result per command.
`timescale 1ns / 1ps

module q15a_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  q15a_pkg::pipe_t                   in_pipe,
    output logic                              out_valid,
    output logic signed [q15a_pkg::WordW-1:0] out_result
);

    logic                              valid_reg;
    logic signed [q15a_pkg::WordW-1:0] result_reg;
    logic signed [q15a_pkg::WordW-1:0] result_next;

    logic signed [2*q15a_pkg::WordW-1:0] shifted;
    logic signed [q15a_pkg::WordW-1:0]   sum_sat;
    logic signed [q15a_pkg::WordW-1:0]   mul_sat;
    logic signed [q15a_pkg::WordW-1:0]   div_res;

    always_comb
    begin
        if (in_pipe.sum > $signed({q15a_pkg::Q15Max[q15a_pkg::WordW-1], q15a_pkg::Q15Max}))
            sum_sat = q15a_pkg::Q15Max;
        else if (in_pipe.sum < $signed({q15a_pkg::Q15Min[q15a_pkg::WordW-1],
                                        q15a_pkg::Q15Min}))
            sum_sat = q15a_pkg::Q15Min;
        else
            sum_sat = in_pipe.sum[q15a_pkg::WordW-1:0];

        // Arithmetic shift floors toward minus infinity.
        shifted = in_pipe.prod >>> q15a_pkg::FracW;
        if (shifted > 32'(q15a_pkg::Q15Max))
            mul_sat = q15a_pkg::Q15Max;
        else if (shifted < 32'(q15a_pkg::Q15Min))
            mul_sat = q15a_pkg::Q15Min;
        else
            mul_sat = shifted[q15a_pkg::WordW-1:0];

        if (in_pipe.div_zero)
        begin
            if (in_pipe.a_zero)
                div_res = '0;
            else
                div_res = in_pipe.a_neg ? q15a_pkg::Q15Min : q15a_pkg::Q15Max;
        end
        else if (in_pipe.ovf || in_pipe.quo[q15a_pkg::WordW-1])
            // Magnitude of 32768 or more: only the negative side holds 32768 exactly.
            div_res = in_pipe.q_neg ? q15a_pkg::Q15Min : q15a_pkg::Q15Max;
        else
            div_res = in_pipe.q_neg ? q15a_pkg::WordW'(~in_pipe.quo + 1'b1) : in_pipe.quo;

        case (in_pipe.cmd) inside
            q15a_pkg::CMD_ADD,
            q15a_pkg::CMD_SUB: result_next = sum_sat;
            q15a_pkg::CMD_MUL: result_next = mul_sat;
            default:           result_next = div_res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
